@@ hw/rtl/tslbt_pkg.sv @@
// ----------------------------------------------------------------------------
// tslbt_pkg
// Shared types and constants of the two-skew load-aware bucket table.
// ----------------------------------------------------------------------------
package tslbt_pkg;

    // Fixed field widths
    localparam int BALL_W    = 14;
    localparam int NBALLS    = 2 ** BALL_W;
    localparam int IDX_W     = 10;
    localparam int OCC_W     = 5;
    localparam int COUNT_MAX = 2 ** OCC_W - 1;
    localparam int STATUS_W  = 3;
    localparam int BKT_OUT_W = 11;
    localparam int EXTRA_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    // Parameter defaults
    localparam int DEF_BUCKETS_PER_SKEW = 1024;
    localparam int DEF_BASE_WAYS        = 8;
    localparam int DEF_FILL_LIMIT       = 16;

    // Configuration reset values
    localparam logic [EXTRA_W-1:0] EXTRA_RST = 4'd2;
    localparam logic               TIE_RST   = 1'b0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIE   = 1'b1;

    typedef enum logic [1:0] {
        OP_REMOVE   = 2'd0,
        OP_INSERT   = 2'd1,
        OP_RELOCATE = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_NOT_PLACED    = 3'd1,
        ST_ALREADY       = 3'd2,
        ST_NO_SPILL      = 3'd3,
        ST_SPILL_PENDING = 3'd4
    } t_status;

    // Memory strobes from the sequencer to the table store
    typedef struct packed {
        logic occ_rd_a;
        logic occ_rd_b;
        logic occ_we;
        logic ball_rd;
        logic ball_we;
    } t_mem_ctl;

endpackage

@@ hw/rtl/two_skew_load_aware_bucket_table_unit.sv @@
// ----------------------------------------------------------------------------
// two_skew_load_aware_bucket_table_unit
// Two-choice bucket insert with occupancy counters, ball home map and
// spill relocation.
// ----------------------------------------------------------------------------
// One item is in flight at a time. An accepted item passes through a read
// step, which reduces the candidate indexes modulo BUCKETS_PER_SKEW and
// issues the memory reads, and an execute step, which registers the result
// of an insert, relocate, rejected item or unused operation code. A remove
// of a placed ball adds a remove step, since its bucket is known only
// after the ball map read and the counter is then read and written back.
// The next item is taken the cycle after a result is registered; a result
// held in the output register by a stall holds the next item in its execute
// or remove step until the register frees up. After reset both memories are
// swept clear over max(16384, 2 * BUCKETS_PER_SKEW) entries, during which
// input is stalled; configuration writes are taken at all times.
module two_skew_load_aware_bucket_table_unit
    import tslbt_pkg::*;
#(
    parameter int BUCKETS_PER_SKEW = DEF_BUCKETS_PER_SKEW,
    parameter int BASE_WAYS        = DEF_BASE_WAYS,
    parameter int FILL_LIMIT       = DEF_FILL_LIMIT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_operation,
    input  logic [BALL_W-1:0]    i_ball_id,
    input  logic [IDX_W-1:0]     i_index_skew0,
    input  logic [IDX_W-1:0]     i_index_skew1,
    input  logic                 i_tie_pick,
    input  logic [IDX_W-1:0]     i_spill_candidate,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BKT_OUT_W-1:0] o_bucket_index,
    output logic [OCC_W-1:0]     o_prior_count,
    output logic                 o_spill_pending,
    output logic                 o_cuckoo_retry
);

    localparam int AW       = $clog2(2 * BUCKETS_PER_SKEW);
    localparam int RECIP_SH = 2 * IDX_W;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = IDX_W + RECIP_W;
    localparam int BPS_W    = 17;
    localparam int QM_W     = IDX_W + BPS_W;
    localparam int LIM      = (FILL_LIMIT < COUNT_MAX) ? FILL_LIMIT : COUNT_MAX;
    localparam int THR_W    = OCC_W + 1;

    // Reciprocal for index mod BUCKETS_PER_SKEW; exact for 10-bit indexes
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SH) / BUCKETS_PER_SKEW + 1);
    localparam logic [BPS_W-1:0]   BPS_C  = BPS_W'(BUCKETS_PER_SKEW);
    localparam logic [AW-1:0]      SKEW1_BASE = AW'(BUCKETS_PER_SKEW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_REM
    } t_state;

    // control
    t_state               r_state,      n_state;
    logic                 r_pending,    n_pending;
    logic                 r_pend_skew,  n_pend_skew;
    logic [BALL_W-1:0]    r_pend_ball,  n_pend_ball;
    logic [EXTRA_W-1:0]   r_extra;
    logic                 r_tie_policy;
    logic                 r_out_valid,  n_out_valid;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [BKT_OUT_W-1:0] r_out_bucket, n_out_bucket;
    logic [OCC_W-1:0]     r_out_prior,  n_out_prior;
    logic                 r_out_spill,  n_out_spill;
    logic                 r_out_retry,  n_out_retry;

    // item datapath
    t_op                  r_op;
    logic [BALL_W-1:0]    r_ball;
    logic                 r_tie;
    logic [IDX_W-1:0]     r_raw_a;
    logic [IDX_W-1:0]     r_raw_b;
    logic [IDX_W-1:0]     r_q_a;
    logic [IDX_W-1:0]     r_q_b;
    logic [AW-1:0]        r_addr_a,     n_addr_a;
    logic [AW-1:0]        r_addr_b,     n_addr_b;

    logic                 in_acc;
    logic                 out_free;
    logic                 clr_busy;
    logic                 emit;
    logic [IDX_W-1:0]     raw_a_in;
    logic [PROD_W-1:0]    prod_a;
    logic [PROD_W-1:0]    prod_b;
    logic [QM_W-1:0]      qm_a;
    logic [QM_W-1:0]      qm_b;
    logic [IDX_W-1:0]     rem_a;
    logic [IDX_W-1:0]     rem_b;
    logic [AW-1:0]        c0_addr;
    logic [AW-1:0]        c1_addr;
    logic [AW-1:0]        reloc_addr;
    logic [THR_W-1:0]     sum_thr;
    logic [THR_W-1:0]     thr;

    t_mem_ctl             mem_ctl;
    logic [AW-1:0]        occ_addr_a;
    logic [AW-1:0]        occ_addr_b;
    logic [AW-1:0]        occ_waddr;
    logic [OCC_W-1:0]     occ_wdata;
    logic [BALL_W-1:0]    ball_waddr;
    logic [AW:0]          ball_wdata;
    logic [OCC_W-1:0]     occ_a;
    logic [OCC_W-1:0]     occ_b;
    logic [AW:0]          ball_data;
    logic                 ball_valid;
    logic [AW-1:0]        ball_home;

    logic                 pick_b;
    logic [AW-1:0]        pick_addr;
    logic [OCC_W-1:0]     pick_cnt;

    tslbt_store #(
        .BUCKETS_PER_SKEW (BUCKETS_PER_SKEW),
        .AW               (AW)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (mem_ctl),
        .i_occ_addr_a (occ_addr_a),
        .i_occ_addr_b (occ_addr_b),
        .i_occ_waddr  (occ_waddr),
        .i_occ_wdata  (occ_wdata),
        .i_ball_raddr (r_ball),
        .i_ball_waddr (ball_waddr),
        .i_ball_wdata (ball_wdata),
        .o_occ_a      (occ_a),
        .o_occ_b      (occ_b),
        .o_ball_data  (ball_data),
        .o_clr_busy   (clr_busy)
    );

    assign o_in_stall = (r_state != S_IDLE) || clr_busy;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Stage one of the index reduction: quotient from the input ports
    assign raw_a_in = (t_op'(i_operation) == OP_RELOCATE) ? i_spill_candidate
                                                           : i_index_skew0;
    assign prod_a   = PROD_W'(raw_a_in) * PROD_W'(RECIP);
    assign prod_b   = PROD_W'(i_index_skew1) * PROD_W'(RECIP);

    // Stage two: remainder from the registered quotient
    assign qm_a  = QM_W'(r_q_a) * QM_W'(BPS_C);
    assign qm_b  = QM_W'(r_q_b) * QM_W'(BPS_C);
    assign rem_a = r_raw_a - qm_a[IDX_W-1:0];
    assign rem_b = r_raw_b - qm_b[IDX_W-1:0];

    assign c0_addr    = AW'(rem_a);
    assign c1_addr    = SKEW1_BASE + AW'(rem_b);
    assign reloc_addr = (r_pend_skew ? '0 : SKEW1_BASE) + AW'(rem_a);

    assign sum_thr = THR_W'(BASE_WAYS) + THR_W'(r_extra);
    assign thr     = (sum_thr > THR_W'(LIM)) ? THR_W'(LIM) : sum_thr;

    assign ball_valid = ball_data[AW];
    assign ball_home  = ball_data[AW-1:0];

    // Less loaded candidate; ties follow the tie bit unless policy forces skew 0
    assign pick_b    = (occ_b < occ_a)
                    || ((occ_b == occ_a) && !r_tie_policy && r_tie);
    assign pick_addr = pick_b ? r_addr_b : r_addr_a;
    assign pick_cnt  = pick_b ? occ_b : occ_a;

    always_comb begin
        n_state      = r_state;
        n_pending    = r_pending;
        n_pend_skew  = r_pend_skew;
        n_pend_ball  = r_pend_ball;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_bucket = r_out_bucket;
        n_out_prior  = r_out_prior;
        n_out_spill  = r_out_spill;
        n_out_retry  = r_out_retry;
        n_addr_a     = r_addr_a;
        n_addr_b     = r_addr_b;
        emit         = 1'b0;
        mem_ctl      = '0;
        occ_addr_a   = r_addr_a;
        occ_addr_b   = r_addr_b;
        occ_waddr    = r_addr_a;
        occ_wdata    = '0;
        ball_waddr   = r_ball;
        ball_wdata   = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RD;
                end
            end

            S_RD: begin
                n_addr_a         = (r_op == OP_RELOCATE) ? reloc_addr : c0_addr;
                n_addr_b         = c1_addr;
                occ_addr_a       = n_addr_a;
                occ_addr_b       = n_addr_b;
                mem_ctl.occ_rd_a = 1'b1;
                mem_ctl.occ_rd_b = 1'b1;
                mem_ctl.ball_rd  = 1'b1;
                n_state          = S_EXEC;
            end

            S_EXEC: begin
                n_out_status = ST_OK;
                n_out_bucket = '0;
                n_out_prior  = '0;
                n_out_retry  = 1'b0;
                case (r_op)
                    OP_REMOVE: begin
                        if (ball_valid) begin
                            // Free the ball now, fetch its bucket counter
                            mem_ctl.ball_we  = 1'b1;
                            mem_ctl.occ_rd_a = 1'b1;
                            occ_addr_a       = ball_home;
                            n_addr_a         = ball_home;
                            n_state          = S_REM;
                        end else if (out_free) begin
                            emit         = 1'b1;
                            n_out_status = ST_NOT_PLACED;
                        end
                    end
                    OP_INSERT: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (r_pending) begin
                                n_out_status = ST_SPILL_PENDING;
                            end else if (ball_valid) begin
                                n_out_status = ST_ALREADY;
                            end else begin
                                n_out_bucket = BKT_OUT_W'(pick_addr);
                                n_out_prior  = pick_cnt;
                                if (THR_W'(pick_cnt) >= thr) begin
                                    // Bucket full: leave the ball pending
                                    n_pending   = 1'b1;
                                    n_pend_ball = r_ball;
                                    n_pend_skew = pick_b;
                                end else begin
                                    mem_ctl.occ_we  = 1'b1;
                                    occ_waddr       = pick_addr;
                                    occ_wdata       = pick_cnt + OCC_W'(1);
                                    mem_ctl.ball_we = 1'b1;
                                    ball_wdata      = {1'b1, pick_addr};
                                end
                            end
                        end
                    end
                    OP_RELOCATE: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (!r_pending) begin
                                n_out_status = ST_NO_SPILL;
                            end else begin
                                n_out_bucket = BKT_OUT_W'(r_addr_a);
                                n_out_prior  = occ_a;
                                if (THR_W'(occ_a) < thr) begin
                                    mem_ctl.occ_we  = 1'b1;
                                    occ_wdata       = occ_a + OCC_W'(1);
                                    mem_ctl.ball_we = 1'b1;
                                    ball_waddr      = r_pend_ball;
                                    ball_wdata      = {1'b1, r_addr_a};
                                    n_pending       = 1'b0;
                                end else begin
                                    // Candidate full: try the other skew next
                                    n_pend_skew = !r_pend_skew;
                                    n_out_retry = 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit = 1'b1;
                        end
                    end
                endcase
            end

            S_REM: begin
                if (out_free) begin
                    emit         = 1'b1;
                    n_out_status = ST_OK;
                    n_out_bucket = BKT_OUT_W'(r_addr_a);
                    n_out_prior  = occ_a;
                    n_out_retry  = 1'b0;
                    if (occ_a != '0) begin
                        mem_ctl.occ_we = 1'b1;
                        occ_wdata      = occ_a - OCC_W'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_spill = n_pending;
            n_state     = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pending    <= 1'b0;
            r_pend_skew  <= 1'b0;
            r_pend_ball  <= '0;
            r_extra      <= EXTRA_RST;
            r_tie_policy <= TIE_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pending    <= n_pending;
            r_pend_skew  <= n_pend_skew;
            r_pend_ball  <= n_pend_ball;
            r_out_valid  <= n_out_valid;
            // Hold the result payload until a new result is loaded
            if (emit) begin
                r_out_status <= n_out_status;
                r_out_bucket <= n_out_bucket;
                r_out_prior  <= n_out_prior;
                r_out_spill  <= n_out_spill;
                r_out_retry  <= n_out_retry;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EXTRA: r_extra      <= i_cfg_data[EXTRA_W-1:0];
                    CFG_TIE:   r_tie_policy <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Item fields and reduced indexes
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= t_op'(i_operation);
            r_ball  <= i_ball_id;
            r_tie   <= i_tie_pick;
            r_raw_a <= raw_a_in;
            r_raw_b <= i_index_skew1;
            r_q_a   <= prod_a[RECIP_SH +: IDX_W];
            r_q_b   <= prod_b[RECIP_SH +: IDX_W];
        end
        r_addr_a <= n_addr_a;
        r_addr_b <= n_addr_b;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_bucket_index  = r_out_bucket;
    assign o_prior_count   = r_out_prior;
    assign o_spill_pending = r_out_spill;
    assign o_cuckoo_retry  = r_out_retry;

    // Rejected items carry no bucket and no count
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_bucket_index == '0)
            && (o_prior_count == '0) && !o_cuckoo_retry)
        else $error("rejected item reports bucket data");

    // A counter never passes the highest possible threshold
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_prior_count <= OCC_W'(LIM)))
        else $error("occupancy above limit");

    // A retry leaves the ball pending
    a_retry_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cuckoo_retry) |-> o_spill_pending)
        else $error("retry without pending spill");

    // Only an insert can raise the pending flag
    a_pending_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pending) |-> ($past(r_state) == S_EXEC) && ($past(r_op) == OP_INSERT))
        else $error("pending spill raised outside insert");

endmodule

@@ hw/rtl/tslbt_store.sv @@
// ----------------------------------------------------------------------------
// tslbt_store
// Bucket occupancy memory (two read ports, one write port) and ball home
// memory, with the clearing sweep that runs after reset.
// ----------------------------------------------------------------------------
module tslbt_store
    import tslbt_pkg::*;
#(
    parameter int BUCKETS_PER_SKEW = DEF_BUCKETS_PER_SKEW,
    parameter int AW               = $clog2(2 * BUCKETS_PER_SKEW)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_ctl          i_ctl,
    input  logic [AW-1:0]     i_occ_addr_a,
    input  logic [AW-1:0]     i_occ_addr_b,
    input  logic [AW-1:0]     i_occ_waddr,
    input  logic [OCC_W-1:0]  i_occ_wdata,
    input  logic [BALL_W-1:0] i_ball_raddr,
    input  logic [BALL_W-1:0] i_ball_waddr,
    input  logic [AW:0]       i_ball_wdata,
    output logic [OCC_W-1:0]  o_occ_a,
    output logic [OCC_W-1:0]  o_occ_b,
    output logic [AW:0]       o_ball_data,
    output logic              o_clr_busy
);

    localparam int NBKT  = 2 * BUCKETS_PER_SKEW;
    localparam int CLR_N = (NBKT > NBALLS) ? NBKT : NBALLS;
    localparam int CW    = $clog2(CLR_N);

    logic [OCC_W-1:0] r_occ_mem [NBKT];
    logic [AW:0]      r_ball_mem [NBALLS];

    logic [CW-1:0]    r_clr_cnt;
    logic             r_clr_busy;
    logic [OCC_W-1:0] r_occ_a;
    logic [OCC_W-1:0] r_occ_b;
    logic [AW:0]      r_ball_data;

    logic             occ_we;
    logic [AW-1:0]    occ_waddr;
    logic [OCC_W-1:0] occ_wdata;
    logic             ball_we;
    logic [BALL_W-1:0] ball_waddr;
    logic [AW:0]      ball_wdata;

    // Sweep both memories to zero after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt  <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            if (r_clr_cnt == CW'(CLR_N - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_cnt <= r_clr_cnt + CW'(1);
            end
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            occ_we     = 1'b1;
            occ_waddr  = r_clr_cnt[AW-1:0];
            occ_wdata  = '0;
            ball_we    = 1'b1;
            ball_waddr = r_clr_cnt[BALL_W-1:0];
            ball_wdata = '0;
        end else begin
            occ_we     = i_ctl.occ_we;
            occ_waddr  = i_occ_waddr;
            occ_wdata  = i_occ_wdata;
            ball_we    = i_ctl.ball_we;
            ball_waddr = i_ball_waddr;
            ball_wdata = i_ball_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            r_occ_mem[occ_waddr] <= occ_wdata;
        end
        if (i_ctl.occ_rd_a) begin
            r_occ_a <= r_occ_mem[i_occ_addr_a];
        end
        if (i_ctl.occ_rd_b) begin
            r_occ_b <= r_occ_mem[i_occ_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ball_we) begin
            r_ball_mem[ball_waddr] <= ball_wdata;
        end
        if (i_ctl.ball_rd) begin
            r_ball_data <= r_ball_mem[i_ball_raddr];
        end
    end

    assign o_occ_a     = r_occ_a;
    assign o_occ_b     = r_occ_b;
    assign o_ball_data = r_ball_data;
    assign o_clr_busy  = r_clr_busy;

endmodule
